[hw/rtl/lwps_pkg.sv]
// Package with shared constants and helpers for the polarity scorer.
`timescale 1ns / 1ps
`default_nettype none
package lwps_pkg;
  localparam int LexiconEntriesDef = 256;
  localparam int MaxWordCharsDef = 32;
  localparam logic [7:0] SpaceChar = 8'h20;

  function automatic logic is_letter(input logic [7:0] c);
    is_letter = ((c >= 8'h41) && (c <= 8'h5a)) || ((c >= 8'h61) && (c <= 8'h7a));
  endfunction

  function automatic logic signed [15:0] sat_add(input logic signed [15:0] a,
                                                 input logic signed [7:0] b);
    logic signed [16:0] s;
    s = 17'(a) + 17'(b);
    if (s > 17'sd32767) sat_add = 16'sh7fff;
    else if (s < -17'sd32768) sat_add = 16'sh8000;
    else sat_add = s[15:0];
  endfunction
endpackage
`default_nettype wire

[hw/rtl/lwps_match.sv]
// Lexicon store and iterative byte compare unit used for word lookup.
`timescale 1ns / 1ps
`default_nettype none
module lwps_match import lwps_pkg::*; #(
  parameter int LEXICON_ENTRIES = LexiconEntriesDef,
  parameter int MAX_WORD_CHARS = MaxWordCharsDef,
  localparam int EW = $clog2(LEXICON_ENTRIES + 1),
  localparam int EI = (LEXICON_ENTRIES > 1) ? $clog2(LEXICON_ENTRIES) : 1,
  localparam int LW = $clog2(MAX_WORD_CHARS + 1),
  localparam int LI = $clog2(MAX_WORD_CHARS)
) (
  input  wire logic clk,
  input  wire logic rst_n,
  // Lexicon load.
  input  wire logic ld_en,
  input  wire logic [7:0] ld_char,
  input  wire logic ld_last,
  input  wire logic signed [7:0] ld_pol,
  // Word buffer write.
  input  wire logic wb_en,
  input  wire logic [LI-1:0] wb_addr,
  input  wire logic [7:0] wb_char,
  // Lookup.
  input  wire logic start,
  input  wire logic [LW-1:0] word_len,
  output logic done,
  output logic signed [7:0] result
);
  localparam logic [2:0] S_IDLE = 3'd0, S_HDR = 3'd1, S_HDRW = 3'd2, S_CMP = 3'd3,
                         S_CMPW = 3'd4, S_NEXT = 3'd5, S_DONE = 3'd6;
  localparam int AW = $clog2(LEXICON_ENTRIES * MAX_WORD_CHARS);

  logic [7:0] lex_mem [LEXICON_ENTRIES*MAX_WORD_CHARS];
  logic [LW-1:0] len_mem [LEXICON_ENTRIES];
  logic [7:0] pol_mem [LEXICON_ENTRIES];
  logic [7:0] wbuf [MAX_WORD_CHARS];

  logic [EW-1:0] count_r;
  logic [LW-1:0] lidx_r;
  logic lover_r;
  logic [2:0] state_r;
  logic [EW-1:0] ent_r;
  logic [LW-1:0] pos_r;
  logic [7:0] lex_q_r, wb_q_r, pol_q_r;
  logic [LW-1:0] len_q_r;
  logic signed [7:0] result_r;
  logic full;
  logic [AW-1:0] wr_addr, rd_addr;

  assign full = count_r == EW'(LEXICON_ENTRIES);
  assign done = state_r == S_DONE;
  assign result = result_r;
  assign wr_addr = AW'(count_r[EI-1:0]) * AW'(MAX_WORD_CHARS) + AW'(lidx_r[LI-1:0]);
  assign rd_addr = AW'(ent_r[EI-1:0]) * AW'(MAX_WORD_CHARS) + AW'(pos_r[LI-1:0]);

  always_ff @(posedge clk) begin
    if (ld_en && lidx_r < LW'(MAX_WORD_CHARS) && !full)
      lex_mem[wr_addr] <= ld_char;
    if (ld_en && ld_last && !full && !lover_r) begin
      len_mem[count_r[EI-1:0]] <= lidx_r < LW'(MAX_WORD_CHARS) ? lidx_r + 1'b1 : lidx_r;
      pol_mem[count_r[EI-1:0]] <= ld_pol;
    end
    if (wb_en) wbuf[wb_addr] <= wb_char;
    lex_q_r <= lex_mem[rd_addr];
    wb_q_r <= wbuf[pos_r[LI-1:0]];
    len_q_r <= len_mem[ent_r[EI-1:0]];
    pol_q_r <= pol_mem[ent_r[EI-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      lidx_r <= '0;
      lover_r <= 1'b0;
      state_r <= S_IDLE;
    end else begin
      if (ld_en) begin
        if (lidx_r < LW'(MAX_WORD_CHARS)) lidx_r <= lidx_r + 1'b1;
        else lover_r <= 1'b1;
        if (ld_last) begin
          if (!full && !(lover_r || lidx_r >= LW'(MAX_WORD_CHARS))) count_r <= count_r + 1'b1;
          lidx_r <= '0;
          lover_r <= 1'b0;
        end
      end
      unique case (state_r)
        S_IDLE: if (start) begin
          ent_r <= '0;
          pos_r <= '0;
          result_r <= '0;
          state_r <= S_NEXT;
        end
        S_NEXT: begin
          if (ent_r >= count_r) state_r <= S_DONE;
          else begin
            pos_r <= '0;
            state_r <= S_HDR;
          end
        end
        S_HDR: state_r <= S_HDRW;
        S_HDRW: begin
          if (len_q_r != word_len) begin
            ent_r <= ent_r + 1'b1;
            state_r <= S_NEXT;
          end else state_r <= S_CMP;
        end
        S_CMP: begin
          if (pos_r == word_len) begin
            result_r <= pol_q_r;
            state_r <= S_DONE;
          end else state_r <= S_CMPW;
        end
        S_CMPW: begin
          if (lex_q_r != wb_q_r) begin
            ent_r <= ent_r + 1'b1;
            state_r <= S_NEXT;
          end else begin
            pos_r <= pos_r + 1'b1;
            state_r <= S_HDR;
          end
        end
        S_DONE: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[hw/rtl/lexicon_word_polarity_scorer_core.sv]
// Top level of the lexicon word polarity scorer.
//
//  Channel  Ports                                              Direction
//  in       in_valid/in_ready, mode, char_value, last, pol     into block
//  out      out_valid/out_ready, polarity, flags, total        out of block
//
// Lexicon bytes and letters without a word end are accepted without leaving idle. A word end
// walks the lexicon one entry at a time through a single byte comparator; each entry's
// length is checked first, and only an entry of matching length has its bytes compared.
// Reset clears the entry count, load position, word state and total.
// The block takes no new transfer while a result waits on out_ready.
// The compare sequencer rereads the memories while the pipeline waits for it.
`timescale 1ns / 1ps
`default_nettype none
module lexicon_word_polarity_scorer_core import lwps_pkg::*; #(
  parameter int LEXICON_ENTRIES = LexiconEntriesDef,
  parameter int MAX_WORD_CHARS = MaxWordCharsDef
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic in_mode,
  input  wire logic [7:0] in_char_value,
  input  wire logic in_last,
  input  wire logic signed [7:0] in_entry_polarity,
  output logic out_valid,
  input  wire logic out_ready,
  output logic signed [7:0] out_word_polarity,
  output logic out_word_valid,
  output logic out_word_too_long,
  output logic signed [15:0] out_comment_total,
  output logic out_comment_done
);
  localparam int LW = $clog2(MAX_WORD_CHARS + 1);
  localparam int LI = $clog2(MAX_WORD_CHARS);

  // Control: idle, waiting for lookup, result pending.
  localparam logic [1:0] C_IDLE = 2'd0, C_LOOK = 2'd1, C_OUT = 2'd2;

  logic [1:0] ctl_r;
  logic [LW-1:0] wlen_r;
  logic over_r;
  logic signed [15:0] total_r;
  logic last_r;
  logic acc;
  logic is_let, ends;
  logic lk_done;
  logic signed [7:0] lk_res;

  assign in_ready = ctl_r == C_IDLE;
  assign out_valid = ctl_r == C_OUT;
  assign acc = in_valid && in_ready;
  assign is_let = is_letter(in_char_value);
  assign ends = (in_char_value == SpaceChar) || in_last;

  lwps_match #(.LEXICON_ENTRIES(LEXICON_ENTRIES), .MAX_WORD_CHARS(MAX_WORD_CHARS)) u_match (
    .clk, .rst_n,
    .ld_en(acc && !in_mode), .ld_char(in_char_value), .ld_last(in_last),
    .ld_pol(in_entry_polarity),
    .wb_en(acc && in_mode && is_let && wlen_r < LW'(MAX_WORD_CHARS)),
    .wb_addr(wlen_r[LI-1:0]), .wb_char(in_char_value | 8'h20),
    .start(acc && in_mode && ends && !over_r && !is_let && wlen_r != '0
           || acc && in_mode && in_last && is_let && !over_r
              && wlen_r < LW'(MAX_WORD_CHARS)),
    .word_len(wlen_r), .done(lk_done), .result(lk_res)
  );

  // A letter that ends the comment is appended in the same cycle that starts the
  // lookup; the buffer and length already hold it when the compare reads them.
  logic [LW-1:0] wlen_new;
  logic over_new;
  always_comb begin
    wlen_new = wlen_r;
    over_new = over_r;
    if (is_let) begin
      if (wlen_r < LW'(MAX_WORD_CHARS)) wlen_new = wlen_r + 1'b1;
      else over_new = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= C_IDLE;
      wlen_r <= '0;
      over_r <= 1'b0;
      total_r <= '0;
      last_r <= 1'b0;
    end else begin
      unique case (ctl_r)
        C_IDLE: if (acc && in_mode) begin
          last_r <= in_last;
          wlen_r <= wlen_new;
          over_r <= over_new;
          if (ends) begin
            if (wlen_new == '0) begin
              // A space with no word pending ends nothing; only the comment's
              // last character still reports the total.
              if (in_last) begin
                out_word_valid <= 1'b0;
                out_word_too_long <= 1'b0;
                out_word_polarity <= '0;
                out_comment_total <= total_r;
                out_comment_done <= 1'b1;
                ctl_r <= C_OUT;
              end
            end else if (over_new) begin
              out_word_valid <= 1'b1;
              out_word_too_long <= 1'b1;
              out_word_polarity <= '0;
              out_comment_total <= total_r;
              out_comment_done <= in_last;
              ctl_r <= C_OUT;
            end else ctl_r <= C_LOOK;
          end
        end
        C_LOOK: if (lk_done) begin
          out_word_valid <= 1'b1;
          out_word_too_long <= 1'b0;
          out_word_polarity <= lk_res;
          out_comment_total <= sat_add(total_r, lk_res);
          out_comment_done <= last_r;
          total_r <= sat_add(total_r, lk_res);
          ctl_r <= C_OUT;
        end
        C_OUT: if (out_ready) begin
          wlen_r <= '0;
          over_r <= 1'b0;
          if (last_r) total_r <= '0;
          ctl_r <= C_IDLE;
        end
        default: ctl_r <= C_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
